// ----- rtl/tbed_pkg.sv -----
// Shared constants for the time bucket encoder/decoder.
`timescale 1ns / 1ps
package tbed_pkg;

    localparam int TIME_W   = 64;
    localparam int PERIOD_W = 63;
    localparam int COUNT_W  = 31;
    localparam int LOOK_W   = 63;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_NS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_CNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_NS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOKBACK_NS = 2'd3;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [TIME_W-1:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [TIME_W-1:0] INT64_MIN = 64'h8000_0000_0000_0000;

endpackage

// ----- rtl/time_bucket_encode_decode.sv -----
// Top level: cyclic time bucket encoder/decoder pipeline.
//
//  channel | ports                                         | dir
//  s_      | s_valid s_ready s_mode s_event_ns             | in
//          | s_reference_ns s_bucket_in                    |
//  m_      | m_valid m_ready m_bucket_out m_start_ns       | out
//          | m_out_of_range                                |
//  cfg_    | cfg_wr_en cfg_index cfg_data                  | in
//
// One item per cycle while m_ready does not stall it; each item passes the input register,
// the two 64-stage dividers (index = diff / period, bucket = index mod count) and
// seven further register steps before m_valid rises.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// The whole pipeline holds while the output register waits on m_ready.
`timescale 1ns / 1ps
module time_bucket_encode_decode (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic signed [63:0] s_event_ns,
    input  logic signed [63:0] s_reference_ns,
    input  logic signed [63:0] s_bucket_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [30:0]        m_bucket_out,
    output logic signed [63:0] m_start_ns,
    output logic               m_out_of_range
);

    typedef struct packed {
        logic        mode;
        logic        invalid;
        logic        oor;
        logic [30:0] bkt;
        logic        neg;
    } side1_t;

    typedef struct packed {
        logic        mode;
        logic        invalid;
        logic        oor;
        logic [30:0] bkt;
        logic [63:0] idx;
    } side2_t;

    localparam int S1_W = $bits(side1_t);
    localparam int S2_W = $bits(side2_t);

    // configuration
    logic [62:0] period_reg;
    logic [30:0] count_reg;
    logic [63:0] origin_reg;
    logic [62:0] lookback_reg;
    logic [62:0] p_eff;
    logic [30:0] c_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= 63'd1;
            count_reg    <= 31'd1;
            origin_reg   <= 64'd0;
            lookback_reg <= 63'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tbed_pkg::REG_PERIOD_NS:   period_reg   <= cfg_data[62:0];
                tbed_pkg::REG_PERIOD_CNT:  count_reg    <= cfg_data[30:0];
                tbed_pkg::REG_ORIGIN_NS:   origin_reg   <= cfg_data;
                tbed_pkg::REG_LOOKBACK_NS: lookback_reg <= cfg_data[62:0];
                default: ;
            endcase
        end
    end

    assign p_eff = (period_reg == '0) ? 63'd1 : period_reg;
    assign c_eff = (count_reg == '0) ? 31'd1 : count_reg;

    logic en;
    logic out_v_reg;
    assign en      = !out_v_reg || m_ready;
    assign s_ready = en;

    // S0: input register
    logic        v0_reg;
    logic        mode0_reg;
    logic [63:0] ev0_reg, ref0_reg, b0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v0_reg <= 1'b0;
        else if (en)  v0_reg <= s_valid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            mode0_reg <= s_mode;
            ev0_reg   <= s_event_ns;
            ref0_reg  <= s_reference_ns;
            b0_reg    <= s_bucket_in;
        end
    end

    // S1: signed difference to origin, range checks
    logic [63:0] a1;
    logic [64:0] diff1, ndiff1, rlb1;
    logic        late1, old1, oor1;
    side1_t      side1_next;
    logic [63:0] mag1_next;

    always_comb begin
        a1     = (mode0_reg == tbed_pkg::MODE_DECODE) ? ref0_reg : ev0_reg;
        diff1  = {a1[63], a1} - {origin_reg[63], origin_reg};
        ndiff1 = 65'd0 - diff1;
        mag1_next = diff1[64] ? ndiff1[63:0] : diff1[63:0];
        late1  = ($signed(ev0_reg) > $signed(ref0_reg));
        rlb1   = {ref0_reg[63], ref0_reg} - {2'b00, lookback_reg};
        old1   = ($signed({ev0_reg[63], ev0_reg}) < $signed(rlb1));
        oor1   = b0_reg[63] || (b0_reg[62:0] >= {32'd0, c_eff});
        side1_next.mode    = mode0_reg;
        side1_next.invalid = late1 || old1;
        side1_next.oor     = oor1;
        side1_next.bkt     = b0_reg[30:0];
        side1_next.neg     = diff1[64];
    end

    logic        v1_reg;
    logic [63:0] mag1_reg;
    side1_t      side1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= v0_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg  <= mag1_next;
            side1_reg <= side1_next;
        end
    end

    // period index divider
    logic            d1_v;
    logic [63:0]     d1_q;
    logic [62:0]     d1_r;
    logic [S1_W-1:0] d1_side;

    tbed_div_pipe #(.NUM_W(64), .DEN_W(63), .SIDE_W(S1_W)) u_div_period (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v1_reg),
        .in_num   (mag1_reg),
        .den      (p_eff),
        .in_side  (side1_reg),
        .out_valid(d1_v),
        .out_quo  (d1_q),
        .out_rem  (d1_r),
        .out_side (d1_side)
    );

    // S2: floor and saturate to int64
    side1_t      sd1;
    logic [64:0] qq2;
    logic [64:0] nqq2;
    logic [63:0] idx2_next;

    always_comb begin
        sd1  = side1_t'(d1_side);
        qq2  = {1'b0, d1_q} + {64'd0, (d1_r != '0)};
        nqq2 = 65'd0 - qq2;
        if (!sd1.neg) begin
            idx2_next = d1_q[63] ? tbed_pkg::INT64_MAX : d1_q;
        end else begin
            idx2_next = (qq2[64] || qq2[63]) ? tbed_pkg::INT64_MIN : nqq2[63:0];
        end
    end

    logic        v2_reg;
    side2_t      side2_reg;
    logic [63:0] m2;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= d1_v;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg.mode    <= sd1.mode;
            side2_reg.invalid <= sd1.invalid;
            side2_reg.oor     <= sd1.oor;
            side2_reg.bkt     <= sd1.bkt;
            side2_reg.idx     <= idx2_next;
        end
    end

    assign m2 = side2_reg.idx[63] ? (64'd0 - side2_reg.idx) : side2_reg.idx;

    // bucket = index mod count
    logic            d2_v;
    logic [63:0]     d2_q;
    logic [30:0]     d2_r;
    logic [S2_W-1:0] d2_side;

    tbed_div_pipe #(.NUM_W(64), .DEN_W(31), .SIDE_W(S2_W)) u_div_count (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v2_reg),
        .in_num   (m2),
        .den      (c_eff),
        .in_side  (side2_reg),
        .out_valid(d2_v),
        .out_quo  (d2_q),
        .out_rem  (d2_r),
        .out_side (d2_side)
    );

    // S3: non-negative remainder
    side2_t      sd2;
    logic [30:0] am3_next;

    always_comb begin
        sd2 = side2_t'(d2_side);
        if (!sd2.idx[63] || d2_r == '0) am3_next = d2_r;
        else                            am3_next = c_eff - d2_r;
    end

    logic        v3_reg;
    side2_t      side3_reg;
    logic [30:0] am3_reg;
    logic [63:0] quo3_unused;

    assign quo3_unused = d2_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= d2_v;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            side3_reg <= sd2;
            am3_reg   <= am3_next;
        end
    end

    // S4: target index = anchor + offset to requested bucket
    logic [31:0] k4;
    logic [64:0] s4, ns4;
    logic [63:0] mag4_next;
    logic [30:0] enc4_next;

    always_comb begin
        if (side3_reg.bkt >= am3_reg)
            k4 = {1'b0, side3_reg.bkt} - {1'b0, am3_reg};
        else
            k4 = {1'b0, side3_reg.bkt} + {1'b0, c_eff} - {1'b0, am3_reg};
        s4  = {side3_reg.idx[63], side3_reg.idx} + {33'd0, k4};
        ns4 = 65'd0 - s4;
        mag4_next = s4[64] ? ns4[63:0] : s4[63:0];
        enc4_next = side3_reg.invalid ? c_eff : am3_reg;
    end

    logic        v4_reg, mode4_reg, oor4_reg, neg4_reg;
    logic [63:0] mag4_reg;
    logic [30:0] enc4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en)  v4_reg <= v3_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            mode4_reg <= side3_reg.mode;
            oor4_reg  <= side3_reg.oor;
            neg4_reg  <= s4[64];
            mag4_reg  <= mag4_next;
            enc4_reg  <= enc4_next;
        end
    end

    // S5: partial products of mag * period
    logic        v5_reg, mode5_reg, oor5_reg, neg5_reg;
    logic [30:0] enc5_reg;
    logic [63:0] pll_reg, plh_reg, phl_reg, phh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (en)  v5_reg <= v4_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            mode5_reg <= mode4_reg;
            oor5_reg  <= oor4_reg;
            neg5_reg  <= neg4_reg;
            enc5_reg  <= enc4_reg;
            pll_reg   <= {32'd0, mag4_reg[31:0]}  * {32'd0, p_eff[31:0]};
            plh_reg   <= {32'd0, mag4_reg[31:0]}  * {33'd0, p_eff[62:32]};
            phl_reg   <= {32'd0, mag4_reg[63:32]} * {32'd0, p_eff[31:0]};
            phh_reg   <= {32'd0, mag4_reg[63:32]} * {33'd0, p_eff[62:32]};
        end
    end

    // S6: combine partial products, flag overflow past 64 bits
    logic [127:0] full6;

    assign full6 = {64'd0, pll_reg}
                 + {32'd0, plh_reg, 32'd0}
                 + {32'd0, phl_reg, 32'd0}
                 + {phh_reg, 64'd0};

    logic        v6_reg, mode6_reg, oor6_reg, neg6_reg, ovf6_reg;
    logic [30:0] enc6_reg;
    logic [63:0] prod6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (en)  v6_reg <= v5_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            mode6_reg <= mode5_reg;
            oor6_reg  <= oor5_reg;
            neg6_reg  <= neg5_reg;
            enc6_reg  <= enc5_reg;
            ovf6_reg  <= (full6[127:64] != '0);
            prod6_reg <= full6[63:0];
        end
    end

    // S7: origin + product with saturation, output register
    logic [63:0] biased7, res7;
    logic [64:0] sum7;
    logic [63:0] dif7;
    logic [30:0] bucket_next;
    logic [63:0] start_next;
    logic        oor_next;

    always_comb begin
        biased7 = origin_reg ^ tbed_pkg::INT64_MIN;
        sum7    = {1'b0, biased7} + {1'b0, prod6_reg};
        dif7    = biased7 - prod6_reg;
        if (ovf6_reg)
            res7 = neg6_reg ? tbed_pkg::INT64_MIN : tbed_pkg::INT64_MAX;
        else if (!neg6_reg)
            res7 = sum7[64] ? tbed_pkg::INT64_MAX : (sum7[63:0] ^ tbed_pkg::INT64_MIN);
        else
            res7 = (biased7 < prod6_reg) ? tbed_pkg::INT64_MIN
                                         : (dif7 ^ tbed_pkg::INT64_MIN);
        if (mode6_reg == tbed_pkg::MODE_ENCODE) begin
            bucket_next = enc6_reg;
            start_next  = '0;
            oor_next    = 1'b0;
        end else begin
            bucket_next = '0;
            start_next  = oor6_reg ? 64'd0 : res7;
            oor_next    = oor6_reg;
        end
    end

    logic        out_mode_reg;
    logic [30:0] out_bucket_reg;
    logic [63:0] out_start_reg;
    logic        out_oor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (en)  out_v_reg <= v6_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            out_mode_reg   <= mode6_reg;
            out_bucket_reg <= bucket_next;
            out_start_reg  <= start_next;
            out_oor_reg    <= oor_next;
        end
    end

    assign m_valid        = out_v_reg;
    assign m_bucket_out   = out_bucket_reg;
    assign m_start_ns     = out_start_reg;
    assign m_out_of_range = out_oor_reg;

`ifndef ASSERT_OFF
    a_enc_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && out_mode_reg == tbed_pkg::MODE_ENCODE
        |-> out_start_reg == '0 && !out_oor_reg)
        else $error("encode item carries decode fields");

    a_enc_bucket: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && out_mode_reg == tbed_pkg::MODE_ENCODE
        |-> out_bucket_reg <= c_eff)
        else $error("encode bucket above count");

    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg && out_oor_reg
        |-> out_start_reg == '0 && out_bucket_reg == '0 &&
            out_mode_reg == tbed_pkg::MODE_DECODE)
        else $error("out-of-range item with nonzero fields");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !out_v_reg && !v0_reg)
        else $error("valid survives reset");
`endif

endmodule

// ----- rtl/tbed_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module tbed_div_pipe #(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 63,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo,
    output logic [DEN_W-1:0]  out_rem,
    output logic [SIDE_W-1:0] out_side
);

    logic              vld_reg  [1:NUM_W];
    logic [NUM_W-1:0]  work_reg [1:NUM_W];
    logic [DEN_W-1:0]  rem_reg  [1:NUM_W];
    logic [SIDE_W-1:0] side_reg [1:NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic              src_v;
        logic [NUM_W-1:0]  src_work;
        logic [DEN_W-1:0]  src_rem;
        logic [SIDE_W-1:0] src_side;
        logic [DEN_W:0]    tmp;
        logic [DEN_W:0]    diff;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;
        logic [NUM_W-1:0]  work_next;

        if (s == 0) begin : g_first
            assign src_v    = in_valid;
            assign src_work = in_num;
            assign src_rem  = '0;
            assign src_side = in_side;
        end else begin : g_mid
            assign src_v    = vld_reg[s];
            assign src_work = work_reg[s];
            assign src_rem  = rem_reg[s];
            assign src_side = side_reg[s];
        end

        always_comb begin
            tmp       = {src_rem, src_work[NUM_W-1]};
            diff      = tmp - {1'b0, den};
            ge        = (tmp >= {1'b0, den});
            rem_next  = ge ? diff[DEN_W-1:0] : tmp[DEN_W-1:0];
            work_next = {src_work[NUM_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s+1] <= 1'b0;
            end else if (en) begin
                vld_reg[s+1] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                work_reg[s+1] <= work_next;
                rem_reg[s+1]  <= rem_next;
                side_reg[s+1] <= src_side;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W];
    assign out_quo   = work_reg[NUM_W];
    assign out_rem   = rem_reg[NUM_W];
    assign out_side  = side_reg[NUM_W];

endmodule

// ----- dv/tb_time_bucket_encode_decode.sv -----
// Self-checking testbench for the time bucket encoder/decoder.
`timescale 1ns / 1ps
module tb_time_bucket_encode_decode;

    localparam int  LIMIT_CYCLES = 900000;
    localparam int  DRAIN_CYCLES = 160;
    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic        mode;
        logic [63:0] event_ns;
        logic [63:0] reference_ns;
        logic [63:0] bucket_in;
    } ts_item_t;

    typedef struct packed {
        logic [30:0] bucket;
        logic [63:0] start;
        logic        oor;
    } bucket_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_mode = 1'b0;
    logic signed [63:0] s_event_ns = '0;
    logic signed [63:0] s_reference_ns = '0;
    logic signed [63:0] s_bucket_in = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [30:0]        m_bucket_out;
    logic signed [63:0] m_start_ns;
    logic               m_out_of_range;

    // shadow of the block's registers
    logic [62:0] sh_period = 63'd1;
    logic [30:0] sh_count = 31'd1;
    logic [63:0] sh_origin = '0;
    logic [62:0] sh_lookback = 63'd1;

    ts_item_t       pending_q[$];
    bucket_result_t expected_q[$];
    int  errors = 0;
    int  cycles = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  hold_cnt = 0;
    bit  hold_req = 0;
    bit  hold_done = 0;

    time_bucket_encode_decode uut (.*);

    always #5 aclk = ~aclk;

    function automatic logic [63:0] period_floor(logic [63:0] a, logic [63:0] b,
                                                 logic [63:0] p);
        logic [63:0] mag, q;
        if ($signed(a) >= $signed(b)) begin
            mag = a - b;
            q = mag / p;
            return (q > tbed_pkg::INT64_MAX) ? tbed_pkg::INT64_MAX : q;
        end
        mag = b - a;
        q = mag / p + ((mag % p) != 0 ? 64'd1 : 64'd0);
        if (q >= SIGN64)
            return tbed_pkg::INT64_MIN;
        return -q;
    endfunction

    function automatic logic [63:0] wrap_bucket(logic [63:0] idx, logic [63:0] c);
        logic [63:0] r;
        if (!idx[63])
            return idx % c;
        r = (-idx) % c;
        return (r != 0) ? c - r : 64'd0;
    endfunction

    function automatic bucket_result_t predict_bucket(ts_item_t it);
        bucket_result_t res;
        logic [63:0] p, c, lb, anchor, am, k, mag, amag, prod, biased, s;
        logic        neg;
        p = sh_period == 0 ? 64'd1 : {1'b0, sh_period};
        c = sh_count == 0 ? 64'd1 : {33'd0, sh_count};
        lb = {1'b0, sh_lookback};
        res = '0;
        if (it.mode == tbed_pkg::MODE_ENCODE) begin
            res.bucket = 31'(wrap_bucket(period_floor(it.event_ns, sh_origin, p), c));
            if ($signed(it.event_ns) > $signed(it.reference_ns))
                res.bucket = c[30:0];
            else if ($signed(it.reference_ns) >= $signed(tbed_pkg::INT64_MIN + lb) &&
                     $signed(it.event_ns) < $signed(it.reference_ns - lb))
                res.bucket = c[30:0];
            return res;
        end
        if (it.bucket_in[63] || it.bucket_in >= c) begin
            res.oor = 1'b1;
            return res;
        end
        anchor = period_floor(it.reference_ns, sh_origin, p);
        am = wrap_bucket(anchor, c);
        k = (it.bucket_in >= am) ? it.bucket_in - am : it.bucket_in + c - am;
        if (!anchor[63]) begin
            mag = anchor + k;
            neg = 1'b0;
        end else begin
            amag = -anchor;
            if (k >= amag) begin
                mag = k - amag;
                neg = 1'b0;
            end else begin
                mag = amag - k;
                neg = 1'b1;
            end
        end
        if (mag != 0 && mag > 64'hFFFF_FFFF_FFFF_FFFF / p) begin
            res.start = neg ? tbed_pkg::INT64_MIN : tbed_pkg::INT64_MAX;
        end else begin
            prod = mag * p;
            biased = sh_origin ^ SIGN64;
            if (!neg) begin
                s = biased + prod;
                res.start = (s < biased) ? tbed_pkg::INT64_MAX : (s ^ SIGN64);
            end else begin
                res.start = (biased < prod) ? tbed_pkg::INT64_MIN
                                            : ((biased - prod) ^ SIGN64);
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_q.push_back(predict_bucket({s_mode, s_event_ns,
                                                     s_reference_ns, s_bucket_in}));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    ts_item_t it;
                    it = pending_q.pop_front();
                    s_valid <= 1'b1;
                    s_mode <= it.mode;
                    s_event_ns <= it.event_ns;
                    s_reference_ns <= it.reference_ns;
                    s_bucket_in <= it.bucket_in;
                    send_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected item bucket=%0d start=%0d oor=%0b",
                             $time, m_bucket_out, m_start_ns, m_out_of_range);
                    errors <= errors + 1;
                end else begin
                    bucket_result_t e;
                    e = expected_q.pop_front();
                    if (e.bucket !== m_bucket_out || e.start !== m_start_ns ||
                        e.oor !== m_out_of_range) begin
                        $display("%0t: mismatch expected bucket=%0d start=%0d oor=%0b",
                                 $time, e.bucket, $signed(e.start), e.oor);
                        $display("%0t:          actual   bucket=%0d start=%0d oor=%0b",
                                 $time, m_bucket_out, m_start_ns, m_out_of_range);
                        errors <= errors + 1;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_cnt <= 400;
                m_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_gap <= pick_gap();
            end
        end
    end

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 7))
            0: return tbed_pkg::INT64_MAX;
            1: return tbed_pkg::INT64_MIN;
            2: return {{32{1'b0}}, $urandom} - 64'h8000_0000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            tbed_pkg::REG_PERIOD_NS:   sh_period = val[62:0];
            tbed_pkg::REG_PERIOD_CNT:  sh_count = val[30:0];
            tbed_pkg::REG_ORIGIN_NS:   sh_origin = val;
            tbed_pkg::REG_LOOKBACK_NS: sh_lookback = val[62:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(logic [63:0] p, logic [63:0] c, logic [63:0] o,
                              logic [63:0] lb);
        cfg_write(tbed_pkg::REG_PERIOD_NS, p);
        cfg_write(tbed_pkg::REG_PERIOD_CNT, c);
        cfg_write(tbed_pkg::REG_ORIGIN_NS, o);
        cfg_write(tbed_pkg::REG_LOOKBACK_NS, lb);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || s_valid || expected_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic add(logic m, logic [63:0] ev, logic [63:0] rf, logic [63:0] bk);
        pending_q.push_back({m, ev, rf, bk});
    endtask

    task automatic add_random(int n);
        ts_item_t it;
        logic [63:0] lb;
        for (int i = 0; i < n; i++) begin
            it.mode = 1'($urandom_range(0, 1));
            it.event_ns = rand64();
            it.reference_ns = rand64();
            it.bucket_in = rand64();
            if ($urandom_range(0, 9) < 7) begin
                // mostly events inside the window and in-range buckets
                lb = {1'b0, sh_lookback};
                if ($urandom_range(0, 1))
                    it.reference_ns = sh_origin + {{32{1'b0}}, $urandom} * sh_period;
                it.event_ns = it.reference_ns - ({$urandom, $urandom} % (lb + 2));
                it.bucket_in = {32'd0, $urandom_range(0, sh_count)};
            end
            pending_q.push_back(it);
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_config(64'd7, 64'd5, -64'sd3, 64'd100);
        add(tbed_pkg::MODE_ENCODE, 64'd50, 64'd50, 64'd0);
        add(tbed_pkg::MODE_ENCODE, 64'd51, 64'd50, 64'd0);          // future event
        add(tbed_pkg::MODE_ENCODE, -64'sd50, 64'd50, 64'd0);        // at window edge
        add(tbed_pkg::MODE_ENCODE, -64'sd51, 64'd50, 64'd0);        // too old
        add(tbed_pkg::MODE_ENCODE, -64'sd20, -64'sd5, 64'd0);       // before origin
        add(tbed_pkg::MODE_ENCODE, tbed_pkg::INT64_MIN, tbed_pkg::INT64_MIN, 64'd0);
        add(tbed_pkg::MODE_ENCODE, tbed_pkg::INT64_MAX, tbed_pkg::INT64_MAX, 64'd0);
        add(tbed_pkg::MODE_DECODE, 64'd0, 64'd40, -64'sd1);
        add(tbed_pkg::MODE_DECODE, 64'd0, 64'd40, 64'd5);
        add(tbed_pkg::MODE_DECODE, 64'd0, 64'd40, 64'd0);
        add(tbed_pkg::MODE_DECODE, 64'd0, -64'sd40, 64'd4);
        add(tbed_pkg::MODE_DECODE, 64'd0, 64'd40, tbed_pkg::INT64_MIN);
        add(tbed_pkg::MODE_DECODE, 64'd0, 64'd40, tbed_pkg::INT64_MAX);
        add(tbed_pkg::MODE_DECODE, 64'd0, tbed_pkg::INT64_MIN, 64'd3);
        add(tbed_pkg::MODE_DECODE, 64'd0, tbed_pkg::INT64_MAX, 64'd2);
        wait_idle();

        // huge index and start overflow
        set_config(64'd1, 64'h7FFF_FFFF, tbed_pkg::INT64_MAX, 64'h7FFF_FFFF_FFFF_FFFF);
        add(tbed_pkg::MODE_ENCODE, tbed_pkg::INT64_MIN, tbed_pkg::INT64_MAX, 64'd0);
        add(tbed_pkg::MODE_DECODE, 64'd0, tbed_pkg::INT64_MIN, 64'h7FFF_FFFE);
        add(tbed_pkg::MODE_DECODE, 64'd0, tbed_pkg::INT64_MAX, 64'd12345);
        wait_idle();
        set_config(64'd0, 64'd0, tbed_pkg::INT64_MIN, 64'd0);     // zero period and count
        add(tbed_pkg::MODE_ENCODE, tbed_pkg::INT64_MAX, tbed_pkg::INT64_MAX, 64'd0);
        add(tbed_pkg::MODE_DECODE, 64'd0, tbed_pkg::INT64_MAX, 64'd0);
        add(tbed_pkg::MODE_DECODE, 64'd0, 64'd0, 64'd1);
        wait_idle();

        set_config(64'd1000, 64'd24, 64'd1_000_000, 64'd50_000);
        hold_req = 1;
        add_random(180);
        wait_idle();
        set_config(64'h7FFF_FFFF_FFFF_FFFF, 64'd3, tbed_pkg::INT64_MAX,
                   64'h7FFF_FFFF_FFFF_FFFF);
        add_random(170);
        wait_idle();
        set_config(64'd1, 64'h7FFF_FFFF, tbed_pkg::INT64_MIN, 64'd1);
        add_random(170);
        wait_idle();
        set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom});
        add_random(170);
        wait_idle();
        set_config({32'd0, $urandom_range(1, 50)}, {32'd0, $urandom_range(1, 16)},
                   rand64(), {32'd0, $urandom_range(1, 2000)});
        add_random(180);
        wait_idle();
        set_config({$urandom_range(0, 15), $urandom}, {32'd0, $urandom_range(1, 1000)},
                   rand64(), {$urandom, $urandom});
        add_random(170);
        wait_idle();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
